// File: rtl/core/lmeb_pkg.sv
// ----------------------------------------------------------------------------
// lmeb_pkg
// Shared types, register codes and word-format constants for the list-mode
// event builder.
// ----------------------------------------------------------------------------
package lmeb_pkg;

	// Detector count default and command queue depth
	localparam int DETECTORS_DEFAULT = 2;
	localparam int QUEUE_DEPTH       = 2;

	// Field widths
	localparam int WORD_W     = 32;
	localparam int TS_W       = 48;
	localparam int CH_W       = 12;
	localparam int VAL_W      = 16;
	localparam int TIME_W     = 64;
	localparam int CFG_DATA_W = 28;
	localparam int REG_IDX_W  = 3;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_TICKS     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WRAP_LIMIT       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SLOW_ENERGY_BASE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SLOW_TIME_BASE   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FAST_ENERGY_BASE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FAST_TIME_BASE   = 3'd5;

	// Register reset values
	localparam logic [15:0]   WINDOW_TICKS_RST     = 16'd9;
	localparam logic [27:0]   WRAP_LIMIT_RST       = 28'h000001a;
	localparam logic [CH_W-1:0] SLOW_ENERGY_BASE_RST = 12'd64;
	localparam logic [CH_W-1:0] SLOW_TIME_BASE_RST   = 12'd80;
	localparam logic [CH_W-1:0] FAST_ENERGY_BASE_RST = 12'd72;
	localparam logic [CH_W-1:0] FAST_TIME_BASE_RST   = 12'd88;

	// Word format
	localparam logic [WORD_W-1:0] ADC_MASK    = 32'hc0000000;
	localparam logic [WORD_W-1:0] SYNC_MASK   = 32'hc0f00000;
	localparam logic [WORD_W-1:0] SYNC_MATCH  = 32'h80400000;
	localparam logic [WORD_W-1:0] FILLER_WORD = 32'h5e5e5e5e;
	localparam logic [TS_W-1:0]   TS_HIGH_KEEP = 48'hfffff0000000;
	localparam logic [TS_W-1:0]   WRAP_STEP    = 48'h000010000000;
	localparam logic [6:0]        IGNORED_CARD = 7'd99;
	localparam logic [2:0]        FAST_TIME_BAD_CODE = 3'b111;

	// Slot kinds carried from front to back
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_NONE   = 3'd0;
	localparam kind_t KIND_SLOW_E = 3'd1;
	localparam kind_t KIND_SLOW_T = 3'd2;
	localparam kind_t KIND_FAST_E = 3'd3;
	localparam kind_t KIND_FAST_T = 3'd4;

	typedef struct packed {
		logic [15:0]     window_ticks;
		logic [27:0]     wrap_limit;
		logic [CH_W-1:0] slow_energy_base;
		logic [CH_W-1:0] slow_time_base;
		logic [CH_W-1:0] fast_energy_base;
		logic [CH_W-1:0] fast_time_base;
	} cfg_t;

	typedef struct packed {
		logic             close;
		kind_t            kind;
		logic [VAL_W-1:0] val;
		logic [TS_W-1:0]  ts;
	} cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0]  slow_energy_0;
		logic [VAL_W-1:0]  fast_energy_0;
		logic [TIME_W-1:0] slow_time_0;
		logic [TIME_W-1:0] fast_time_0;
		logic [VAL_W-1:0]  slow_energy_1;
		logic [VAL_W-1:0]  fast_energy_1;
		logic [TIME_W-1:0] slow_time_1;
		logic [TIME_W-1:0] fast_time_1;
	} event_t;

endpackage

// File: rtl/core/lmeb_queue.sv
// ----------------------------------------------------------------------------
// lmeb_queue
// Small register FIFO that decouples the word decoder from the slot logic.
// ----------------------------------------------------------------------------
module lmeb_queue #(
	parameter int WIDTH = 1,
	parameter int DEPTH = lmeb_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_fire;
	logic             rd_fire;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign wr_fire  = wr_valid && wr_ready;
	assign rd_fire  = rd_valid && rd_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_fire, rd_fire})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/lmeb_front.sv
// ----------------------------------------------------------------------------
// lmeb_front
// Word-pair decoder: drops filler, tracks the timestamp and wrap fix, decides
// event closure and classifies ADC channels into slot commands.
// ----------------------------------------------------------------------------
module lmeb_front #(
	parameter int DETECTORS = lmeb_pkg::DETECTORS_DEFAULT,
	parameter int DET_W     = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lmeb_pkg::cfg_t        cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [31:0]           ts_word,
	input  logic [31:0]           data_word,
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output lmeb_pkg::cmd_t        cmd,
	output logic [DET_W-1:0]      cmd_det
);
	import lmeb_pkg::*;

	logic [TS_W-1:0] ts_current_q;
	logic [TS_W-1:0] ts_previous_q;
	logic            wrap_applied_q;

	logic            in_fire;
	logic            is_filler;
	logic            is_adc;
	logic            is_sync;
	logic            is_card99;
	logic [CH_W-1:0] ch;
	logic [VAL_W-1:0] val;
	logic [TS_W-1:0] ts_merged;
	logic [TS_W-1:0] ts_adc;
	logic [TS_W-1:0] ts_sync;
	logic            apply_wrap;
	logic [TS_W:0]   step;
	logic            close;
	logic [CH_W-1:0] off_se;
	logic [CH_W-1:0] off_st;
	logic [CH_W-1:0] off_fe;
	logic [CH_W-1:0] off_ft;
	kind_t           kind;
	logic [DET_W-1:0] det;

	assign in_ready = cmd_ready;
	assign in_fire  = in_valid && in_ready;

	// Decode the word pair
	always_comb begin
		is_filler = ((ts_word == '0) && (data_word == '0)) ||
			((ts_word == FILLER_WORD) &&
			((data_word == FILLER_WORD) || (data_word == '1)));
		is_adc    = ((data_word & ADC_MASK) == ADC_MASK);
		is_sync   = ((data_word & SYNC_MASK) == SYNC_MATCH);
		ch        = data_word[27:16];
		val       = data_word[15:0];
		is_card99 = (ch[11:5] == IGNORED_CARD);
	end

	// Merge the timestamp, apply the wrap fix and measure the step
	always_comb begin
		ts_merged  = (ts_current_q & TS_HIGH_KEEP) | {16'b0, ts_word};
		apply_wrap = (ts_word <= {4'b0, cfg.wrap_limit}) && !wrap_applied_q;
		ts_adc     = apply_wrap ? ts_merged + WRAP_STEP : ts_merged;
		ts_sync    = {data_word[19:0], 28'b0} | {16'b0, ts_word};
		step       = {1'b0, ts_adc} - {1'b0, ts_previous_q};
		close      = !step[TS_W] && (step[TS_W-1:0] >= {32'b0, cfg.window_ticks});
	end

	// Classify the channel, slow energy first and fast time last
	always_comb begin
		off_se = ch - cfg.slow_energy_base;
		off_st = ch - cfg.slow_time_base;
		off_fe = ch - cfg.fast_energy_base;
		off_ft = ch - cfg.fast_time_base;
		kind   = KIND_NONE;
		det    = '0;
		if (off_se < CH_W'(DETECTORS)) begin
			kind = KIND_SLOW_E;
			det  = off_se[DET_W-1:0];
		end else if (off_st < CH_W'(DETECTORS)) begin
			kind = KIND_SLOW_T;
			det  = off_st[DET_W-1:0];
		end else if (off_fe < CH_W'(DETECTORS)) begin
			kind = KIND_FAST_E;
			det  = off_fe[DET_W-1:0];
		end else if (off_ft < CH_W'(DETECTORS)) begin
			det  = off_ft[DET_W-1:0];
			kind = (val[15:13] == FAST_TIME_BAD_CODE) ? KIND_NONE : KIND_FAST_T;
		end
	end

	// Hand ADC transactions to the back end
	assign cmd_valid = in_valid && !is_filler && is_adc && !is_card99;
	assign cmd.close = close;
	assign cmd.kind  = kind;
	assign cmd.val   = val;
	assign cmd.ts    = ts_adc;
	assign cmd_det   = det;

	// Update timestamp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_current_q   <= '0;
			ts_previous_q  <= '0;
			wrap_applied_q <= 1'b0;
		end else if (in_fire && !is_filler) begin
			if (is_adc) begin
				if (!is_card99) begin
					ts_current_q  <= ts_adc;
					ts_previous_q <= ts_adc;
					if (apply_wrap) begin
						wrap_applied_q <= 1'b1;
					end
				end
			end else if (is_sync) begin
				ts_current_q   <= ts_sync;
				wrap_applied_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/lmeb_back.sv
// ----------------------------------------------------------------------------
// lmeb_back
// Slot keeper: holds the first energy and time per detector, emits the
// collected event on closure and stages it in the output register.
// ----------------------------------------------------------------------------
module lmeb_back #(
	parameter int DETECTORS = lmeb_pkg::DETECTORS_DEFAULT,
	parameter int DET_W     = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  lmeb_pkg::cmd_t   cmd,
	input  logic [DET_W-1:0] cmd_det,
	output logic             out_valid,
	input  logic             out_ready,
	output lmeb_pkg::event_t evt
);
	import lmeb_pkg::*;

	localparam int E_SLOTS = 2 * DETECTORS;
	localparam int F_SLOTS = 4 * DETECTORS;
	localparam int EIDX_W  = $clog2(E_SLOTS);
	localparam int FIDX_W  = $clog2(F_SLOTS);

	logic [VAL_W-1:0]  energy_q [E_SLOTS];
	logic [TIME_W-1:0] time_q   [E_SLOTS];
	logic [F_SLOTS-1:0] filled_q;
	logic              out_valid_q;
	event_t            evt_q;

	logic              pop;
	logic [50:0]       ts5;
	logic [TIME_W-1:0] t;
	logic [EIDX_W-1:0] eidx;
	logic [FIDX_W-1:0] fidx;
	logic              is_energy;
	logic              put_en;
	logic [F_SLOTS-1:0] filled_d;
	event_t            snap;

	assign pop       = cmd_valid && (!cmd.close || !out_valid_q || out_ready);
	assign cmd_ready = pop;
	assign out_valid = out_valid_q;
	assign evt       = evt_q;

	// Time is ts * 40960 + raw value, with 40960 = 5 << 13
	always_comb begin
		ts5 = 51'(cmd.ts) + (51'(cmd.ts) << 2);
		t   = {ts5, 13'b0} + {48'b0, cmd.val};
	end

	// Select the slot for this transaction
	always_comb begin
		eidx      = '0;
		fidx      = '0;
		is_energy = 1'b0;
		case (cmd.kind)
			KIND_SLOW_E: begin
				eidx      = EIDX_W'(cmd_det);
				fidx      = FIDX_W'(cmd_det);
				is_energy = 1'b1;
			end
			KIND_FAST_E: begin
				eidx      = EIDX_W'(DETECTORS) + EIDX_W'(cmd_det);
				fidx      = FIDX_W'(DETECTORS) + FIDX_W'(cmd_det);
				is_energy = 1'b1;
			end
			KIND_SLOW_T: begin
				eidx = EIDX_W'(cmd_det);
				fidx = FIDX_W'(2 * DETECTORS) + FIDX_W'(cmd_det);
			end
			KIND_FAST_T: begin
				eidx = EIDX_W'(DETECTORS) + EIDX_W'(cmd_det);
				fidx = FIDX_W'(3 * DETECTORS) + FIDX_W'(cmd_det);
			end
			default: begin
				eidx = '0;
				fidx = '0;
			end
		endcase
		put_en = (cmd.kind != KIND_NONE) && (cmd.close || !filled_q[fidx]);
	end

	// Next filled flags: clear on closure, then mark the slot taken
	always_comb begin
		filled_d = cmd.close ? '0 : filled_q;
		if (put_en) begin
			filled_d[fidx] = 1'b1;
		end
	end

	// Snapshot the event, empty slots read as zero
	always_comb begin
		snap = '0;
		snap.slow_energy_0 = filled_q[0] ? energy_q[0] : '0;
		snap.fast_energy_0 = filled_q[DETECTORS] ? energy_q[DETECTORS] : '0;
		snap.slow_time_0   = filled_q[2 * DETECTORS] ? time_q[0] : '0;
		snap.fast_time_0   = filled_q[3 * DETECTORS] ? time_q[DETECTORS] : '0;
		if (DETECTORS > 1) begin
			snap.slow_energy_1 = filled_q[1] ? energy_q[1] : '0;
			snap.fast_energy_1 = filled_q[DETECTORS + 1] ? energy_q[DETECTORS + 1] : '0;
			snap.slow_time_1   = filled_q[2 * DETECTORS + 1] ? time_q[1] : '0;
			snap.fast_time_1   = filled_q[3 * DETECTORS + 1] ? time_q[DETECTORS + 1] : '0;
		end
	end

	// Write slot data
	always_ff @(posedge clk) begin
		if (pop && put_en) begin
			if (is_energy) begin
				energy_q[eidx] <= cmd.val;
			end else begin
				time_q[eidx] <= t;
			end
		end
	end

	// Hold the event in the output register
	always_ff @(posedge clk) begin
		if (pop && cmd.close) begin
			evt_q <= snap;
		end
	end

	// Track filled slots and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				filled_q <= filled_d;
			end
			if (pop && cmd.close) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/list_mode_event_builder.sv
// ----------------------------------------------------------------------------
// list_mode_event_builder: accepts one word pair per cycle (throughput 1).
// An event's closing pair passes through the queue, then into the output register.
// Input stalls only when a closing pair waits on an untaken event and the queue fills.
// Reset clears timestamps, wrap flag and slots; registers take defaults.
// ----------------------------------------------------------------------------
module list_mode_event_builder #(
	parameter int DETECTORS = lmeb_pkg::DETECTORS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [lmeb_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [lmeb_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [31:0]                           ts_word,
	input  logic [31:0]                           data_word,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [15:0]                           slow_energy_0,
	output logic [15:0]                           fast_energy_0,
	output logic [63:0]                           slow_time_0,
	output logic [63:0]                           fast_time_0,
	output logic [15:0]                           slow_energy_1,
	output logic [15:0]                           fast_energy_1,
	output logic [63:0]                           slow_time_1,
	output logic [63:0]                           fast_time_1
);
	import lmeb_pkg::*;

	localparam int DET_W = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;
	localparam int Q_W   = $bits(cmd_t) + DET_W;

	cfg_t             cfg_q;
	logic             f_valid;
	logic             f_ready;
	cmd_t             f_cmd;
	logic [DET_W-1:0] f_det;
	logic             b_valid;
	logic             b_ready;
	cmd_t             b_cmd;
	logic [DET_W-1:0] b_det;
	logic [Q_W-1:0]   b_data;
	event_t           evt;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ticks     <= WINDOW_TICKS_RST;
			cfg_q.wrap_limit       <= WRAP_LIMIT_RST;
			cfg_q.slow_energy_base <= SLOW_ENERGY_BASE_RST;
			cfg_q.slow_time_base   <= SLOW_TIME_BASE_RST;
			cfg_q.fast_energy_base <= FAST_ENERGY_BASE_RST;
			cfg_q.fast_time_base   <= FAST_TIME_BASE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WINDOW_TICKS:     cfg_q.window_ticks     <= cfg_data[15:0];
				REG_WRAP_LIMIT:       cfg_q.wrap_limit       <= cfg_data[27:0];
				REG_SLOW_ENERGY_BASE: cfg_q.slow_energy_base <= cfg_data[CH_W-1:0];
				REG_SLOW_TIME_BASE:   cfg_q.slow_time_base   <= cfg_data[CH_W-1:0];
				REG_FAST_ENERGY_BASE: cfg_q.fast_energy_base <= cfg_data[CH_W-1:0];
				REG_FAST_TIME_BASE:   cfg_q.fast_time_base   <= cfg_data[CH_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	lmeb_front #(
		.DETECTORS (DETECTORS),
		.DET_W     (DET_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ts_word   (ts_word),
		.data_word (data_word),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd),
		.cmd_det   (f_det)
	);

	lmeb_queue #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  ({f_cmd, f_det}),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	assign b_cmd = b_data[Q_W-1:DET_W];
	assign b_det = b_data[DET_W-1:0];

	lmeb_back #(
		.DETECTORS (DETECTORS),
		.DET_W     (DET_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.cmd_det   (b_det),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.evt       (evt)
	);

	// Break the event out to the ports
	assign slow_energy_0 = evt.slow_energy_0;
	assign fast_energy_0 = evt.fast_energy_0;
	assign slow_time_0   = evt.slow_time_0;
	assign fast_time_0   = evt.fast_time_0;
	assign slow_energy_1 = evt.slow_energy_1;
	assign fast_energy_1 = evt.fast_energy_1;
	assign slow_time_1   = evt.slow_time_1;
	assign fast_time_1   = evt.fast_time_1;

endmodule

// File: tb/list_mode_event_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_mode_event_builder_tb
// Drives timestamp/data word pairs through the event builder under several
// register settings and compares every emitted event against an in-bench
// model of the decode, timestamp merge, wrap fix and slot collection.
// ----------------------------------------------------------------------------
module list_mode_event_builder_tb;
	import lmeb_pkg::*;

	localparam int ND           = DETECTORS_DEFAULT;
	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_CYCLES = 400000;
	localparam int CHUNK_PAIRS  = 200;

	// Expected-event model and result matching
	class event_ledger;
		bit [15:0]   win;
		bit [27:0]   wrap_lim;
		bit [11:0]   base_se, base_st, base_fe, base_ft;
		bit [47:0]   ts_now, ts_last;
		bit          wrap_done;
		bit [15:0]   energy [2*ND];
		bit [63:0]   stamp [2*ND];
		bit          filled [4*ND];
		event_t      owed_events [$];
		int          errors, n_pairs, n_events;

		function new();
			win      = WINDOW_TICKS_RST;
			wrap_lim = WRAP_LIMIT_RST;
			base_se  = SLOW_ENERGY_BASE_RST;
			base_st  = SLOW_TIME_BASE_RST;
			base_fe  = FAST_ENERGY_BASE_RST;
			base_ft  = FAST_TIME_BASE_RST;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_WINDOW_TICKS:     win      = val[15:0];
				REG_WRAP_LIMIT:       wrap_lim = val;
				REG_SLOW_ENERGY_BASE: base_se  = val[11:0];
				REG_SLOW_TIME_BASE:   base_st  = val[11:0];
				REG_FAST_ENERGY_BASE: base_fe  = val[11:0];
				REG_FAST_TIME_BASE:   base_ft  = val[11:0];
				default: ;
			endcase
		endfunction

		function void clear_slots();
			foreach (energy[i]) energy[i] = '0;
			foreach (stamp[i]) stamp[i] = '0;
			foreach (filled[i]) filled[i] = 1'b0;
		endfunction

		// Detector index of a channel relative to a base, -1 if out of range
		function int det_of(bit [11:0] ch, bit [11:0] base);
			bit [11:0] diff;
			diff = ch - base;
			return (diff < ND) ? int'(diff) : -1;
		endfunction

		function void fill_energy(int kind, int d, bit [15:0] v);
			if (!filled[kind*ND + d]) begin
				filled[kind*ND + d] = 1'b1;
				energy[kind*ND + d] = v;
			end
		endfunction

		function void fill_time(int kind, int d, bit [63:0] v);
			if (!filled[(2 + kind)*ND + d]) begin
				filled[(2 + kind)*ND + d] = 1'b1;
				stamp[kind*ND + d] = v;
			end
		endfunction

		function void absorb_pair(bit [31:0] ts, bit [31:0] dw);
			bit [11:0] ch;
			bit [15:0] val;
			bit [63:0] t;
			longint    step;
			event_t    ev;
			int        d_se, d_st, d_fe, d_ft;
			n_pairs++;
			// drop filler pairs
			if (ts == '0 && dw == '0)
				return;
			if (ts == FILLER_WORD && (dw == FILLER_WORD || dw == '1))
				return;
			if ((dw & ADC_MASK) == ADC_MASK) begin
				ch  = dw[27:16];
				val = dw[15:0];
				if (ch[11:5] == IGNORED_CARD)
					return;
				ts_now = (ts_now & TS_HIGH_KEEP) | {16'b0, ts};
				if (ts <= wrap_lim && !wrap_done) begin
					ts_now    = ts_now + WRAP_STEP;
					wrap_done = 1'b1;
				end
				step = longint'({16'b0, ts_now}) - longint'({16'b0, ts_last});
				// close the event when the step reaches the window
				if (step >= longint'(win)) begin
					ev.slow_energy_0 = energy[0];
					ev.fast_energy_0 = energy[ND];
					ev.slow_time_0   = stamp[0];
					ev.fast_time_0   = stamp[ND];
					ev.slow_energy_1 = energy[1];
					ev.fast_energy_1 = energy[ND + 1];
					ev.slow_time_1   = stamp[1];
					ev.fast_time_1   = stamp[ND + 1];
					owed_events.insert(owed_events.size(), ev);
					clear_slots();
				end
				t = {16'b0, ts_now} * 64'd40960 + {48'b0, val};
				d_se = det_of(ch, base_se);
				d_st = det_of(ch, base_st);
				d_fe = det_of(ch, base_fe);
				d_ft = det_of(ch, base_ft);
				if (d_se >= 0)
					fill_energy(0, d_se, val);
				else if (d_st >= 0)
					fill_time(0, d_st, t);
				else if (d_fe >= 0)
					fill_energy(1, d_fe, val);
				else if (d_ft >= 0) begin
					if (val[15:13] != FAST_TIME_BAD_CODE)
						fill_time(1, d_ft, t);
				end
				ts_last = ts_now;
			end else if ((dw & SYNC_MASK) == SYNC_MATCH) begin
				ts_now    = {dw[19:0], 28'b0} | {16'b0, ts};
				wrap_done = 1'b0;
			end
		endfunction

		function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
			end
		endfunction

		function void match_event(event_t got);
			event_t want;
			n_events++;
			if (owed_events.size() == 0) begin
				errors++;
				$display("%0t: event expected none actual %h", $time, got);
				return;
			end
			want = owed_events.pop_front();
			cmp_field("slow_energy_0", want.slow_energy_0, got.slow_energy_0);
			cmp_field("fast_energy_0", want.fast_energy_0, got.fast_energy_0);
			cmp_field("slow_time_0", want.slow_time_0, got.slow_time_0);
			cmp_field("fast_time_0", want.fast_time_0, got.fast_time_0);
			cmp_field("slow_energy_1", want.slow_energy_1, got.slow_energy_1);
			cmp_field("fast_energy_1", want.fast_energy_1, got.fast_energy_1);
			cmp_field("slow_time_1", want.slow_time_1, got.slow_time_1);
			cmp_field("fast_time_1", want.fast_time_1, got.fast_time_1);
		endfunction

		function int pending();
			return owed_events.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = REG_WINDOW_TICKS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [31:0]           ts_word = '0;
	logic [31:0]           data_word = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [15:0]           slow_energy_0, fast_energy_0, slow_energy_1, fast_energy_1;
	logic [63:0]           slow_time_0, fast_time_0, slow_time_1, fast_time_1;
	event_t                seen_event;

	event_ledger book;
	int          send_idle, recv_idle;
	int          cycles = 0;
	int          n_settings = 1;
	bit [31:0]   ts_run = '0;

	list_mode_event_builder uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.ts_word(ts_word), .data_word(data_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.slow_energy_0(slow_energy_0), .fast_energy_0(fast_energy_0),
		.slow_time_0(slow_time_0), .fast_time_0(fast_time_0),
		.slow_energy_1(slow_energy_1), .fast_energy_1(fast_energy_1),
		.slow_time_1(slow_time_1), .fast_time_1(fast_time_1)
	);

	assign seen_event = {slow_energy_0, fast_energy_0, slow_time_0, fast_time_0,
		slow_energy_1, fast_energy_1, slow_time_1, fast_time_1};

	always #5 clk = ~clk;

	// Stall the result side at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// Record every transaction on both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			book.absorb_pair(ts_word, data_word);
		if (arst_n && out_valid && out_ready)
			book.match_event(seen_event);
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("list_mode_event_builder verification failed");
			$finish;
		end
	end

	function automatic bit [31:0] adc_word(bit [11:0] ch, bit [15:0] val);
		return {2'b11, 2'($urandom_range(0, 3)), ch, val};
	endfunction

	function automatic bit [31:0] sync_word(bit [19:0] hi);
		return {2'b10, 6'($urandom_range(0, 63)), 4'b0100, hi};
	endfunction

	// Present one pair, with random idle cycles ahead of it, and hold until taken
	task automatic send_pair(bit [31:0] ts, bit [31:0] dw);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		ts_word   <= ts;
		data_word <= dw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Hold off input until every owed event has arrived, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		book.set_reg(idx, val);
	endtask

	task automatic load_settings(bit [15:0] win, bit [27:0] wrap,
			bit [11:0] se, bit [11:0] st, bit [11:0] fe, bit [11:0] ft);
		put_reg(REG_WINDOW_TICKS, {12'b0, win});
		put_reg(REG_WRAP_LIMIT, wrap);
		put_reg(REG_SLOW_ENERGY_BASE, {16'b0, se});
		put_reg(REG_SLOW_TIME_BASE, {16'b0, st});
		put_reg(REG_FAST_ENERGY_BASE, {16'b0, fe});
		put_reg(REG_FAST_TIME_BASE, {16'b0, ft});
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	// Mostly well-formed ADC traffic around the configured channels, plus noise
	task automatic random_pair();
		bit [31:0] ts, dw;
		bit [11:0] ch;
		bit [11:0] bases [4];
		int        pick, k, stp;
		bases[0] = book.base_se;
		bases[1] = book.base_st;
		bases[2] = book.base_fe;
		bases[3] = book.base_ft;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			k = $urandom_range(0, 3);
			ts_run = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64);
			ts = ts_run;
			dw = sync_word((k == 0) ? 20'h0 : (k == 1) ? 20'hfffff : 20'($urandom));
		end else if (pick < 10) begin
			k  = $urandom_range(0, 2);
			ts = (k == 0) ? 32'h0 : FILLER_WORD;
			dw = (k == 0) ? 32'h0 : (k == 1) ? FILLER_WORD : 32'hffffffff;
		end else if (pick < 14) begin
			ts = $urandom;
			dw = $urandom;
		end else if (pick < 17) begin
			ts = $urandom;
			dw = $urandom;
			if (dw[31:30] == 2'b11)
				dw[30] = 1'b0;
			if (dw[31:30] == 2'b10 && dw[23:20] == 4'b0100)
				dw[21] = 1'b1;
		end else if (pick < 19) begin
			ts = ts_run;
			dw = adc_word({IGNORED_CARD, 5'($urandom_range(0, 31))}, 16'($urandom));
		end else begin
			k = $urandom_range(0, 99);
			if (k < 50)
				stp = $urandom_range(0, 3);
			else if (k < 80)
				stp = int'(book.win) - 1 + int'($urandom_range(0, 2));
			else if (k < 92)
				stp = $urandom_range(0, 100000);
			else
				stp = -int'($urandom_range(1, 50));
			if (stp < -50)
				stp = 0;
			ts_run = ts_run + stp;
			k = $urandom_range(0, 9);
			ch = (k < 8) ? bases[k/2] + 12'(k % 2) : 12'($urandom);
			ts = ts_run;
			dw = adc_word(ch, 16'($urandom));
		end
		send_pair(ts, dw);
	endtask

	initial begin
		book = new();
		send_idle = 34;
		recv_idle = 88;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs under reset settings
		send_pair(32'h0, 32'h0);
		send_pair(FILLER_WORD, FILLER_WORD);
		send_pair(FILLER_WORD, 32'hffffffff);
		send_pair(32'h100, sync_word(20'h00001));
		send_pair(32'h105, adc_word(12'd64, 16'hffff));
		send_pair(32'h106, adc_word(12'd65, 16'h0001));
		send_pair(32'h107, adc_word(12'd80, 16'h1234));
		send_pair(32'h107, adc_word(12'd81, 16'hffff));
		send_pair(32'h108, adc_word(12'd72, 16'h8000));
		send_pair(32'h108, adc_word(12'd73, 16'h7fff));
		send_pair(32'h109, adc_word(12'd88, 16'h1fff));
		send_pair(32'h109, adc_word(12'd89, 16'he000));
		send_pair(32'h10a, adc_word(12'd89, 16'hdfff));
		send_pair(32'h10a, adc_word(12'd64, 16'h0000));
		send_pair(32'h10b, adc_word({IGNORED_CARD, 5'd0}, 16'h5555));
		send_pair(32'h10b, adc_word({IGNORED_CARD, 5'd31}, 16'haaaa));
		send_pair(32'h10c, adc_word(12'hfff, 16'h4321));
		send_pair(32'h200, 32'h7fffffff);
		send_pair(32'h100, adc_word(12'd66, 16'h0042));
		send_pair(32'h200, adc_word(12'd64, 16'h0007));
		send_pair(32'hf0000003, sync_word(20'hfffff));
		send_pair(32'h3, adc_word(12'd80, 16'h0abc));
		send_pair(32'h20, adc_word(12'd88, 16'h0123));
		send_pair(32'hffffffff, adc_word(12'hfff, 16'hffff));
		send_pair(32'h0, 32'hc0000000);
		settle();

		// Random traffic across register settings and idle patterns
		for (int chunk = 0; chunk < 7; chunk++) begin
			case (chunk)
				0: load_settings(16'd0, 28'd0, 12'd0, 12'd2, 12'd4, 12'd6);
				1: load_settings(16'hffff, 28'hfffffff, 12'd4094, 12'd4092, 12'd4090, 12'd4088);
				2: load_settings(16'd5, 28'd100, 12'd100, 12'd101, 12'd101, 12'd102);
				default: load_settings(16'($urandom_range(1, 20)), 28'($urandom_range(0, 200)),
					12'($urandom_range(0, 4094)), 12'($urandom_range(0, 4094)),
					12'($urandom_range(0, 4094)), 12'($urandom_range(0, 4094)));
			endcase
			if (chunk < 2) begin
				send_idle = 34;
				recv_idle = 88;
			end else if (chunk < 4) begin
				send_idle = 88;
				recv_idle = 34;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int i = 0; i < CHUNK_PAIRS; i++) begin
				random_pair();
				if ($urandom_range(0, 199) == 0)
					settle();
			end
			settle();
		end

		$display("Sent %0d word pairs under %0d register settings", book.n_pairs, n_settings);
		$display("Checked %0d closed events, %0d field errors", book.n_events, book.errors);
		if (book.errors == 0)
			$display("list_mode_event_builder verification clean");
		else
			$display("list_mode_event_builder verification failed");
		$finish;
	end

endmodule
